>>> hdl/alc_pkg.sv
package alc_pkg;

    // Fixed field widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int THR_W      = 17;
    localparam int Q_SHIFT    = 16;
    localparam int TOK_W      = 16;
    localparam int OUT_LA_W   = 4;
    localparam int WARM_W     = 8;
    localparam int BOUND_W    = 4;

    // Opcodes
    localparam logic OP_DRAFT  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_WARMUP_DRAFTS = 3'd0;
    localparam cfg_idx_t REG_MIN_LOOKAHEAD = 3'd1;
    localparam cfg_idx_t REG_MAX_LOOKAHEAD = 3'd2;
    localparam cfg_idx_t REG_MTP_THRESHOLD = 3'd3;
    localparam cfg_idx_t REG_EXP_THRESHOLD = 3'd4;
    localparam cfg_idx_t REG_HIT_THRESHOLD = 3'd5;

    // Configuration reset values
    localparam logic [WARM_W-1:0]  RST_WARMUP_DRAFTS = 8'd3;
    localparam logic [BOUND_W-1:0] RST_MIN_LOOKAHEAD = 4'd1;
    localparam logic [BOUND_W-1:0] RST_MAX_LOOKAHEAD = 4'd2;
    localparam logic [THR_W-1:0]   RST_MTP_THRESHOLD = 17'd49152;
    localparam logic [THR_W-1:0]   RST_EXP_THRESHOLD = 17'd62259;
    localparam logic [THR_W-1:0]   RST_HIT_THRESHOLD = 17'd39322;

    typedef struct packed {
        logic [WARM_W-1:0]  warmup_drafts;
        logic [BOUND_W-1:0] min_lookahead;
        logic [BOUND_W-1:0] max_lookahead;
        logic [THR_W-1:0]   mtp_accept_threshold;
        logic [THR_W-1:0]   expand_threshold;
        logic [THR_W-1:0]   cache_hit_threshold;
    } cfg_t;

    // Per-event classification handed from front to back
    typedef struct packed {
        logic             is_lookup;
        logic             warmup;
        logic             att_zero;
        logic             lkp_zero;
        logic [TOK_W-1:0] rejected;
    } evt_ctl_t;

    localparam int CTL_W = $bits(evt_ctl_t);

endpackage

>>> hdl/alc_front.sv
module alc_front #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_opcode,
    input  logic [15:0]               s_draft_attempts,
    input  logic [15:0]               s_accepted_tokens,
    input  logic                      s_cache_hit,
    input  alc_pkg::cfg_t             cfg,
    input  logic                      q_full,
    output logic                      push,
    output alc_pkg::evt_ctl_t         push_ctl,
    output logic [COUNT_WIDTH-1:0]    push_acc,
    output logic [COUNT_WIDTH-1:0]    push_att,
    output logic [COUNT_WIDTH-1:0]    push_lkp,
    output logic [COUNT_WIDTH-1:0]    push_hit
);
    import alc_pkg::*;

    localparam int CW = COUNT_WIDTH;

    logic [CW-1:0] draft_cnt_reg, draft_cnt_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [CW-1:0] att_reg, att_next;
    logic [CW-1:0] lkp_reg, lkp_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic          accept;

    // saturating add of a token count to a total
    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [TOK_W-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign push    = accept;

    // total updates
    always_comb begin
        draft_cnt_next = draft_cnt_reg;
        acc_next       = acc_reg;
        att_next       = att_reg;
        lkp_next       = lkp_reg;
        hit_next       = hit_reg;
        if (accept) begin
            if (s_opcode == OP_LOOKUP) begin
                lkp_next = sat_add(lkp_reg, TOK_W'(1));
                if (s_cache_hit) begin
                    hit_next = sat_add(hit_reg, TOK_W'(1));
                end
            end else begin
                draft_cnt_next = sat_add(draft_cnt_reg, TOK_W'(1));
                acc_next       = sat_add(acc_reg, s_accepted_tokens);
                att_next       = sat_add(att_reg, s_draft_attempts);
            end
        end
    end

    // classify the word for the back end
    always_comb begin
        push_ctl.is_lookup = (s_opcode == OP_LOOKUP);
        push_ctl.warmup    = draft_cnt_next < CW'(cfg.warmup_drafts);
        push_ctl.att_zero  = (att_next == '0);
        push_ctl.lkp_zero  = (lkp_next == '0);
        if (s_opcode == OP_DRAFT && s_draft_attempts > s_accepted_tokens) begin
            push_ctl.rejected = s_draft_attempts - s_accepted_tokens;
        end else begin
            push_ctl.rejected = '0;
        end
    end

    assign push_acc = acc_next;
    assign push_att = att_next;
    assign push_lkp = lkp_next;
    assign push_hit = hit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draft_cnt_reg <= '0;
            acc_reg       <= '0;
            att_reg       <= '0;
            lkp_reg       <= '0;
            hit_reg       <= '0;
        end else begin
            draft_cnt_reg <= draft_cnt_next;
            acc_reg       <= acc_next;
            att_reg       <= att_next;
            lkp_reg       <= lkp_next;
            hit_reg       <= hit_next;
        end
    end

endmodule

>>> hdl/alc_fifo.sv
module alc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import alc_pkg::*;

    // two-entry queue
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> hdl/alc_back.sv
module alc_back #(
    parameter int COUNT_WIDTH     = 32,
    parameter int LOOKAHEAD_WIDTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  alc_pkg::cfg_t          cfg,
    input  logic                   q_empty,
    input  alc_pkg::evt_ctl_t      q_ctl,
    input  logic [COUNT_WIDTH-1:0] q_acc,
    input  logic [COUNT_WIDTH-1:0] q_att,
    input  logic [COUNT_WIDTH-1:0] q_lkp,
    input  logic [COUNT_WIDTH-1:0] q_hit,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_lookahead,
    output logic                   m_mtp_enabled,
    output logic                   m_warmup_active,
    output logic [15:0]            m_rejected_tokens
);
    import alc_pkg::*;

    localparam int CW    = COUNT_WIDTH;
    localparam int LW    = LOOKAHEAD_WIDTH;
    localparam int LO_W  = CW / 2;
    localparam int HI_W  = CW - LO_W;
    localparam int PLO_W = THR_W + LO_W;
    localparam int PHI_W = THR_W + HI_W;
    localparam int RHS_W = CW + THR_W;
    localparam int PW    = ((LW > BOUND_W) ? LW : BOUND_W) + 1;
    localparam logic [PW-1:0] LA_MAX = PW'((1 << LW) - 1);

    // rate compares: 0 acceptance vs mtp, 1 acceptance vs expand, 2 hits vs cache
    logic [THR_W-1:0] thr [3];
    logic [CW-1:0]    den [3];
    logic [PLO_W-1:0] plo [3];
    logic [PHI_W-1:0] phi [3];

    logic             en;

    // stage 1: partial products
    logic             s1_valid_reg;
    evt_ctl_t         s1_ctl_reg;
    logic [CW-1:0]    s1_acc_reg;
    logic [CW-1:0]    s1_hit_reg;
    logic [PLO_W-1:0] s1_plo_reg [3];
    logic [PHI_W-1:0] s1_phi_reg [3];

    // stage 2: rate flags
    logic [RHS_W-1:0] rhs [3];
    logic [RHS_W-1:0] lhs [3];
    logic             ge  [3];
    logic             meets_mtp, meets_exp, cache_warm;
    logic             s2_valid_reg;
    evt_ctl_t         s2_ctl_reg;
    logic             s2_mtp_reg, s2_exp_reg, s2_cache_reg;

    // output stage: plan
    logic [PW-1:0]    lo, hi, now_ext, up, keep, plan;
    logic             mtp;
    logic [LW-1:0]    la_now_reg, la_now_next;
    logic             m_valid_reg;
    logic [3:0]       m_lookahead_reg;
    logic             m_mtp_reg, m_warm_reg;
    logic [15:0]      m_rej_reg;

    // whole pipeline moves unless the output word is held
    assign en    = !m_valid_reg || m_ready;
    assign q_pop = en && !q_empty;

    // split multiply, threshold times denominator halves
    always_comb begin
        thr[0] = cfg.mtp_accept_threshold;
        thr[1] = cfg.expand_threshold;
        thr[2] = cfg.cache_hit_threshold;
        den[0] = q_att;
        den[1] = q_att;
        den[2] = q_lkp;
        for (int k = 0; k < 3; k++) begin
            plo[k] = PLO_W'(thr[k]) * PLO_W'(den[k][LO_W-1:0]);
            phi[k] = PHI_W'(thr[k]) * PHI_W'(den[k][CW-1:LO_W]);
        end
    end

    // recombine and compare num * 2^16 >= thr * den
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rhs[k] = (RHS_W'(s1_phi_reg[k]) << LO_W) + RHS_W'(s1_plo_reg[k]);
            lhs[k] = RHS_W'({(k == 2) ? s1_hit_reg : s1_acc_reg, {Q_SHIFT{1'b0}}});
            ge[k]  = (lhs[k] >= rhs[k]);
        end
        meets_mtp  = s1_ctl_reg.att_zero ? (thr[0] == '0) : ge[0];
        meets_exp  = s1_ctl_reg.att_zero ? (thr[1] == '0) : ge[1];
        cache_warm = s1_ctl_reg.lkp_zero || ge[2];
    end

    // lookahead plan
    always_comb begin
        lo      = (cfg.min_lookahead == '0) ? PW'(1) : PW'(cfg.min_lookahead);
        hi      = (PW'(cfg.max_lookahead) < lo) ? lo : PW'(cfg.max_lookahead);
        now_ext = PW'(la_now_reg);
        up      = now_ext + PW'(1);
        if (up < lo + PW'(1)) begin
            up = lo + PW'(1);
        end
        keep = (now_ext < lo) ? lo : now_ext;
        if (s2_ctl_reg.warmup || !s2_mtp_reg) begin
            plan = lo;
        end else if (s2_exp_reg) begin
            plan = (up < hi) ? up : hi;
        end else begin
            plan = (keep < hi) ? keep : hi;
        end
        if (plan > LA_MAX) begin
            plan = LA_MAX;
        end
        mtp = !s2_ctl_reg.warmup && s2_cache_reg && s2_mtp_reg && (plan > lo);
        la_now_next = la_now_reg;
        if (en && s2_valid_reg && !s2_ctl_reg.is_lookup) begin
            la_now_next = plan[LW-1:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            la_now_reg   <= '0;
        end else begin
            la_now_reg <= la_now_next;
            if (en) begin
                s1_valid_reg <= !q_empty;
                s2_valid_reg <= s1_valid_reg;
                m_valid_reg  <= s2_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ctl_reg   <= q_ctl;
            s1_acc_reg   <= q_acc;
            s1_hit_reg   <= q_hit;
            s1_plo_reg   <= plo;
            s1_phi_reg   <= phi;
            s2_ctl_reg   <= s1_ctl_reg;
            s2_mtp_reg   <= meets_mtp;
            s2_exp_reg   <= meets_exp;
            s2_cache_reg <= cache_warm;
            if (s2_valid_reg) begin
                m_lookahead_reg <= plan[OUT_LA_W-1:0];
                m_mtp_reg       <= mtp;
                m_warm_reg      <= s2_ctl_reg.warmup;
                m_rej_reg       <= s2_ctl_reg.rejected;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_lookahead       = m_lookahead_reg;
    assign m_mtp_enabled     = m_mtp_reg;
    assign m_warmup_active   = m_warm_reg;
    assign m_rejected_tokens = m_rej_reg;

endmodule

>>> hdl/adaptive_lookahead_controller.sv
// Lookahead governor for speculative decoding.
// Input channel (s_*): one word per event, either a draft report
// (attempted/accepted token counts) or an expert-cache lookup (hit flag).
// Result channel (m_*): exactly one word per event, in order: planned
// lookahead, multi-token prediction enable, warmup flag, rejected tokens.
// Config channel (cfg_*): always ready; cfg_index picks the register,
// cfg_data carries the value, unknown indexes are dropped. Write only
// while no event is in flight.
// Throughput: one event per cycle while m_ready is high. Path: the front
// updates the totals as the word is taken and writes it to the queue;
// the back then runs a registered split multiply stage, a registered
// compare stage and the plan/output register. The plan stage holds the
// stored lookahead, so back-to-back draft reports chain through it in order.
// Stall: while a result word waits with m_ready low the back end freezes;
// the two-word queue between front and back fills and s_ready drops after
// at most two more words.
// Reset (aresetn low, synchronous): all totals and the stored lookahead
// clear, config returns to defaults, queue and pipeline empty.
module adaptive_lookahead_controller #(
    parameter int COUNT_WIDTH     = 32,
    parameter int LOOKAHEAD_WIDTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [15:0] s_draft_attempts,
    input  logic [15:0] s_accepted_tokens,
    input  logic        s_cache_hit,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_lookahead,
    output logic        m_mtp_enabled,
    output logic        m_warmup_active,
    output logic [15:0] m_rejected_tokens,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import alc_pkg::*;

    localparam int CW  = COUNT_WIDTH;
    localparam int Q_W = CTL_W + 4 * CW;

    cfg_t             cfg_reg, cfg_next;
    logic             q_full, q_empty, q_pop, push;
    evt_ctl_t         push_ctl, q_ctl;
    logic [CW-1:0]    push_acc, push_att, push_lkp, push_hit;
    logic [CW-1:0]    q_acc, q_att, q_lkp, q_hit;
    logic [Q_W-1:0]   q_wr_data, q_rd_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WARMUP_DRAFTS: cfg_next.warmup_drafts        = cfg_data[WARM_W-1:0];
                REG_MIN_LOOKAHEAD: cfg_next.min_lookahead        = cfg_data[BOUND_W-1:0];
                REG_MAX_LOOKAHEAD: cfg_next.max_lookahead        = cfg_data[BOUND_W-1:0];
                REG_MTP_THRESHOLD: cfg_next.mtp_accept_threshold = cfg_data[THR_W-1:0];
                REG_EXP_THRESHOLD: cfg_next.expand_threshold     = cfg_data[THR_W-1:0];
                REG_HIT_THRESHOLD: cfg_next.cache_hit_threshold  = cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warmup_drafts        <= RST_WARMUP_DRAFTS;
            cfg_reg.min_lookahead        <= RST_MIN_LOOKAHEAD;
            cfg_reg.max_lookahead        <= RST_MAX_LOOKAHEAD;
            cfg_reg.mtp_accept_threshold <= RST_MTP_THRESHOLD;
            cfg_reg.expand_threshold     <= RST_EXP_THRESHOLD;
            cfg_reg.cache_hit_threshold  <= RST_HIT_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: totals and classification
    alc_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_draft_attempts  (s_draft_attempts),
        .s_accepted_tokens (s_accepted_tokens),
        .s_cache_hit       (s_cache_hit),
        .cfg               (cfg_reg),
        .q_full            (q_full),
        .push              (push),
        .push_ctl          (push_ctl),
        .push_acc          (push_acc),
        .push_att          (push_att),
        .push_lkp          (push_lkp),
        .push_hit          (push_hit)
    );

    // queue between front and back
    assign q_wr_data = {push_ctl, push_acc, push_att, push_lkp, push_hit};
    assign {q_ctl, q_acc, q_att, q_lkp, q_hit} = q_rd_data;

    alc_fifo #(
        .WIDTH (Q_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // back: rate compares and plan
    alc_back #(
        .COUNT_WIDTH     (COUNT_WIDTH),
        .LOOKAHEAD_WIDTH (LOOKAHEAD_WIDTH)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .q_empty           (q_empty),
        .q_ctl             (q_ctl),
        .q_acc             (q_acc),
        .q_att             (q_att),
        .q_lkp             (q_lkp),
        .q_hit             (q_hit),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lookahead       (m_lookahead),
        .m_mtp_enabled     (m_mtp_enabled),
        .m_warmup_active   (m_warmup_active),
        .m_rejected_tokens (m_rejected_tokens)
    );

    // MTP is never granted during warmup
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_mtp_enabled && m_warmup_active))
        else $error("mtp enabled during warmup");

    // input backpressure only follows a held output word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("queue full without output stall");

    // a lookup leaves the draft totals untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !push_ctl.is_lookup ##1 push && push_ctl.is_lookup
        |-> push_att == $past(push_att) && push_acc == $past(push_acc))
        else $error("lookup changed draft totals");

endmodule
